@@ rtl/fdp_pkg.sv @@
// Shared constants, types and helpers for the directory entry parser.
package fdp_pkg;

  // Name store geometry
  localparam int NAME_MAX   = 64;
  localparam int ADDR_W     = $clog2(NAME_MAX);
  localparam int NAME_LIMIT = NAME_MAX - 1;
  localparam int FRAG_UNITS = 13;

  // Entry and result layout
  localparam int ENTRY_W    = 256;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 3;

  // Entry byte codes
  localparam logic [7:0]  END_MARK     = 8'h00;
  localparam logic [7:0]  DELETED_MARK = 8'hE5;
  localparam logic [3:0]  LFN_ATTR     = 4'hF;
  localparam int          VOLUME_BIT   = 3;
  localparam int          LAST_FRAG_BIT = 6;
  localparam logic [15:0] UNIT_FILL    = 16'hFFFF;
  localparam logic [15:0] ASCII_LIMIT  = 16'h0080;
  localparam logic [7:0]  SUBST_CHAR   = 8'h3F;
  localparam logic [7:0]  SPACE_CHAR   = 8'h20;
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        char_t;
  typedef logic [8:0]        span_t;

  // Write and clear command into the name store
  typedef struct packed {
    logic  clr;
    logic  we;
    addr_t waddr;
    char_t wdata;
  } store_cmd_t;

  // One result item
  typedef struct packed {
    logic        kind;
    char_t       name_char;
    logic        char_valid;
    logic [7:0]  attributes;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
    logic        from_long_name;
    logic        last;
  } result_t;

  // Turn one UTF-16 unit of a long-name fragment into a stored character
  function automatic char_t lfn_char(input logic [15:0] u);
    char_t c;
    if (u == 16'h0000 || u == UNIT_FILL) begin
      c = 8'h00;
    end else if (u < ASCII_LIMIT) begin
      c = u[7:0];
    end else begin
      c = SUBST_CHAR;
    end
    return c;
  endfunction

endpackage

@@ rtl/fat32_directory_entry_parser.sv @@
// Top level: FAT32 directory entry parser with long-name assembly.
//
// Input stream: one 32-byte directory entry per transfer on s_axis (bytes 0..31 in
// tdata, byte k at bits 8k up); tuser[0] starts a new directory and clears the
// long-name state and the end flag before the entry is handled.
// Output stream: one transfer per name character on m_axis, tlast on the final
// character of an entry. An end-of-directory marker gives a single transfer with
// result kind set; after it entries are dropped until a new directory starts.
// Deleted entries, volume labels and long-name fragments give no output.
// Timing: an entry is taken only while the parser is idle. It is registered and
// decoded in S_DECIDE, and the first result is then loaded into the output register.
// Short names then give one character per cycle while the receiver takes them; long
// names alternate S_LWAIT, which waits for the registered read of the name store, and
// S_LNEXT, which emits one character. A fragment is filed with one store write per
// character.
// Reset clears all control state and the store's valid bits at once; no clearing
// pass is needed. A stalled receiver holds the output register and the parser
// waits; the next entry is still taken once the final result sits in that register.
module fat32_directory_entry_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_bytes_lo[63:0], entry_bytes_mid_lo[127:64], entry_bytes_mid_hi[191:128],
  // entry_bytes_hi[255:192]
  input  logic [fdp_pkg::ENTRY_W-1:0]        s_axis_tdata,
  // new_directory[0]
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // name_char[7:0], attributes[15:8], first_cluster[47:16], file_size[79:48]
  output logic [fdp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // result_kind[0], char_valid[1], from_long_name[2]
  output logic [fdp_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_FRAG   = 4'd2;
  localparam logic [3:0] S_FTERM  = 4'd3;
  localparam logic [3:0] S_LPRIME = 4'd4;
  localparam logic [3:0] S_LWAIT  = 4'd5;
  localparam logic [3:0] S_LNEXT  = 4'd6;
  localparam logic [3:0] S_SHORT  = 4'd7;

  localparam int FRAG_POS [fdp_pkg::FRAG_UNITS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  logic [3:0]                  state, state_next;
  logic [fdp_pkg::ENTRY_W-1:0] entry;
  fdp_pkg::addr_t              idx, idx_next;
  fdp_pkg::addr_t              rd_addr, rd_addr_next;
  fdp_pkg::char_t              cur_char, cur_char_next;
  fdp_pkg::addr_t              len, len_next;
  logic                        have, have_next;
  logic                        ended, ended_next;

  fdp_pkg::store_cmd_t cmd;
  fdp_pkg::char_t      rdata;
  fdp_pkg::result_t    res, res_base;
  logic                out_load;
  logic                out_free;
  logic                accept;

  logic [7:0]     b0;
  logic [7:0]     attr;
  logic [4:0]     seq;
  fdp_pkg::span_t seq_span;
  logic           seq_bad;
  fdp_pkg::addr_t base;
  fdp_pkg::char_t part_arr [fdp_pkg::FRAG_UNITS];
  fdp_pkg::char_t part_cur;
  fdp_pkg::char_t ext_arr [3];
  fdp_pkg::char_t sn [13];
  logic [3:0]     pre_len;
  logic [1:0]     ext_len;
  logic           has_ext;
  logic [3:0]     sn_len;
  logic [3:0]     sidx;
  logic [3:0]     sidx_inc;
  logic           short_empty;
  logic           short_last;
  logic           long_last;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // Entry decode
  assign b0       = entry[7:0];
  assign attr     = entry[95:88];
  assign seq      = b0[4:0];
  assign seq_span = fdp_pkg::span_t'(seq) * fdp_pkg::span_t'(fdp_pkg::FRAG_UNITS);
  assign seq_bad  = (seq == 5'd0) || (seq_span > fdp_pkg::span_t'(fdp_pkg::NAME_LIMIT));
  assign base     = fdp_pkg::addr_t'(seq_span - fdp_pkg::span_t'(fdp_pkg::FRAG_UNITS));

  // Fragment characters
  always_comb begin
    for (int k = 0; k < fdp_pkg::FRAG_UNITS; k++) begin
      part_arr[k] = fdp_pkg::lfn_char(entry[8*FRAG_POS[k] +: 16]);
    end
  end
  assign part_cur = part_arr[idx[3:0]];

  // Build the 8.3 name, with a dot before any extension
  always_comb begin
    logic stop;
    logic [1:0] ej;
    pre_len = 4'd0;
    stop    = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!stop && entry[8*k +: 8] != fdp_pkg::SPACE_CHAR) begin
        pre_len = pre_len + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    has_ext = (entry[71:64] != fdp_pkg::SPACE_CHAR);
    ext_len = 2'd0;
    stop    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ext_arr[k] = entry[64 + 8*k +: 8];
      if (!stop && ext_arr[k] != fdp_pkg::SPACE_CHAR) begin
        ext_len = ext_len + 2'd1;
      end else begin
        stop = 1'b1;
      end
    end
    sn_len = has_ext ? (pre_len + 4'd1 + {2'b00, ext_len}) : pre_len;
    for (int k = 0; k < 13; k++) begin
      ej    = 2'(4'(k) - pre_len - 4'd1);
      sn[k] = 8'h00;
      if (k < 8 && 4'(k) < pre_len) begin
        sn[k] = entry[8*k +: 8];
      end else if (has_ext && 4'(k) == pre_len) begin
        sn[k] = fdp_pkg::DOT_CHAR;
      end else if (has_ext && 4'(k) > pre_len && ej < 2'd3) begin
        sn[k] = ext_arr[ej];
      end
    end
  end

  assign sidx        = idx[3:0];
  assign sidx_inc    = sidx + 4'd1;
  assign short_empty = (sn_len == 4'd0) || (sn[0] == 8'h00);
  assign short_last  = (sidx_inc == sn_len) || (sn[sidx_inc] == 8'h00);
  assign long_last   = (rdata == 8'h00) ||
                       (idx == fdp_pkg::addr_t'(fdp_pkg::NAME_LIMIT - 1));

  // Fields shared by every character result of the entry
  always_comb begin
    res_base                = '0;
    res_base.attributes     = attr;
    res_base.first_cluster  = {entry[175:160], entry[223:208]};
    res_base.file_size      = entry[255:224];
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    rd_addr_next  = rd_addr;
    cur_char_next = cur_char;
    len_next      = len;
    have_next     = have;
    ended_next    = ended;
    cmd           = '0;
    out_load      = 1'b0;
    res           = res_base;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next   = S_DECIDE;
          idx_next     = '0;
          rd_addr_next = '0;
          if (s_axis_tuser[0]) begin
            cmd.clr    = 1'b1;
            len_next   = '0;
            have_next  = 1'b0;
            ended_next = 1'b0;
          end
        end
      end
      S_DECIDE: begin
        if (ended) begin
          state_next = S_IDLE;
        end else if (b0 == fdp_pkg::END_MARK) begin
          if (out_free) begin
            res        = '0;
            res.kind   = 1'b1;
            res.last   = 1'b1;
            out_load   = 1'b1;
            cmd.clr    = 1'b1;
            len_next   = '0;
            have_next  = 1'b0;
            ended_next = 1'b1;
            state_next = S_IDLE;
          end
        end else if (b0 == fdp_pkg::DELETED_MARK) begin
          have_next  = 1'b0;
          len_next   = '0;
          state_next = S_IDLE;
        end else if (attr[3:0] == fdp_pkg::LFN_ATTR) begin
          if (seq_bad) begin
            have_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            state_next = S_FRAG;
          end
        end else if (attr[fdp_pkg::VOLUME_BIT]) begin
          have_next  = 1'b0;
          len_next   = '0;
          state_next = S_IDLE;
        end else if (have && len != '0) begin
          state_next = S_LPRIME;
        end else begin
          state_next = S_SHORT;
        end
      end
      S_FRAG: begin
        // File one character a cycle, stopping after the first terminator or the last unit
        cmd.we    = 1'b1;
        cmd.waddr = base + idx;
        cmd.wdata = part_cur;
        if (part_cur == 8'h00 || idx == fdp_pkg::addr_t'(fdp_pkg::FRAG_UNITS - 1)) begin
          if (b0[fdp_pkg::LAST_FRAG_BIT]) begin
            idx_next   = (part_cur == 8'h00) ? idx : fdp_pkg::addr_t'(fdp_pkg::FRAG_UNITS);
            state_next = S_FTERM;
          end else begin
            have_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_FTERM: begin
        // Final fragment: terminate the name and fix its length
        cmd.we     = 1'b1;
        cmd.waddr  = base + idx;
        cmd.wdata  = 8'h00;
        len_next   = base + idx;
        have_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_LPRIME: begin
        if (rdata == 8'h00) begin
          if (out_free) begin
            res.from_long_name = 1'b1;
            res.last           = 1'b1;
            out_load           = 1'b1;
            cmd.clr            = 1'b1;
            len_next           = '0;
            have_next          = 1'b0;
            state_next         = S_IDLE;
          end
        end else begin
          cur_char_next = rdata;
          idx_next      = '0;
          rd_addr_next  = fdp_pkg::addr_t'(1);
          state_next    = S_LWAIT;
        end
      end
      S_LWAIT: begin
        state_next = S_LNEXT;
      end
      S_LNEXT: begin
        // Emit the held character once the following one is known
        if (out_free) begin
          res.name_char      = cur_char;
          res.char_valid     = 1'b1;
          res.from_long_name = 1'b1;
          res.last           = long_last;
          out_load           = 1'b1;
          if (long_last) begin
            cmd.clr    = 1'b1;
            len_next   = '0;
            have_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            cur_char_next = rdata;
            idx_next      = idx + 1'b1;
            rd_addr_next  = rd_addr + 1'b1;
            state_next    = S_LWAIT;
          end
        end
      end
      S_SHORT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (short_empty) begin
            res.last = 1'b1;
          end else begin
            res.name_char  = sn[sidx];
            res.char_valid = 1'b1;
            res.last       = short_last;
          end
          if (short_empty || short_last) begin
            cmd.clr    = 1'b1;
            len_next   = '0;
            have_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      have  <= 1'b0;
      ended <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      have  <= have_next;
      ended <= ended_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    rd_addr  <= rd_addr_next;
    cur_char <= cur_char_next;
    if (accept) begin
      entry <= s_axis_tdata;
    end
  end

  fdp_name_store u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  fdp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken result");

  // Store writes and the clear never collide
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.we && cmd.clr))
    else $error("name store written and cleared together");

  // After end of directory an entry without a new directory gives nothing
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && ended) |=> (state == S_IDLE && !m_axis_tvalid || state == S_IDLE))
    else $error("entry handled after end of directory");

  // Read address holds while a long-name character is stalled
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LNEXT && !out_free) |=> $stable(rd_addr))
    else $error("store read address moved during a stall");

endmodule

@@ rtl/fdp_name_store.sv @@
// Long-name store: synchronous memory with per-entry valid bits.
module fdp_name_store (
  input  logic                clk,
  input  logic                rst,
  input  fdp_pkg::store_cmd_t cmd,
  input  fdp_pkg::addr_t      raddr,
  output fdp_pkg::char_t      rdata
);

  fdp_pkg::char_t              mem [fdp_pkg::NAME_MAX];
  logic [fdp_pkg::NAME_MAX-1:0] valid;
  fdp_pkg::char_t              q;
  logic                        qv;

  // Mark written entries; clear all at once
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid <= '0;
    end else if (cmd.we) begin
      valid[cmd.waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    q  <= mem[raddr];
    qv <= valid[raddr];
  end

  // Unwritten entries read as cleared
  assign rdata = qv ? q : 8'h00;

endmodule

@@ rtl/fdp_out_reg.sv @@
// Output register for the result stream.
module fdp_out_reg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  fdp_pkg::result_t                     res,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // name_char[7:0], attributes[15:8], first_cluster[47:16], file_size[79:48]
  output logic [fdp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // result_kind[0], char_valid[1], from_long_name[2]
  output logic [fdp_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output logic                                 m_axis_tlast
);

  fdp_pkg::result_t hold;

  // Valid flag: set on load, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

  assign m_axis_tdata = {hold.file_size, hold.first_cluster, hold.attributes, hold.name_char};
  assign m_axis_tuser = {hold.from_long_name, hold.char_valid, hold.kind};
  assign m_axis_tlast = hold.last;

endmodule
